[src/slip_pkg.sv]
package slip_pkg;

  localparam int MaxFrameDefault = 2048;
  localparam int QueueDepth = 2;

  localparam logic [7:0] SlEnd = 8'hC0;
  localparam logic [7:0] SlEsc = 8'hDB;
  localparam logic [7:0] SlEscEnd = 8'hDC;
  localparam logic [7:0] SlEscEsc = 8'hDD;
  localparam logic [7:0] Icmpv6Nh = 8'h3A;
  localparam logic [7:0] RsType = 8'h85;
  localparam int Ipv6HdrLen = 40;
  localparam logic [3:0] Ipv6Version = 4'd6;

  localparam int PlOffHi = 4;
  localparam int PlOffLo = 5;
  localparam int NhOff = 6;

  typedef enum logic [1:0] {
    VERDICT_FORWARD = 2'd0,
    VERDICT_RS = 2'd1,
    VERDICT_DROP = 2'd2,
    VERDICT_OVERFLOW = 2'd3
  } verdict_e;

  // one decoded item handed from the front to the back
  typedef struct packed {
    logic is_close;
    logic [7:0] data;
  } slip_cmd_t;

endpackage

[src/slip_front.sv]
module slip_front
  import slip_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic [7:0] rx_byte_i,
  input  logic q_full_i,
  output logic push_o,
  output slip_cmd_t cmd_o
);

  logic esc_q, esc_d;
  logic take;

  assign take = in_valid_i && !q_full_i;

  always_comb begin
    esc_d = esc_q;
    push_o = 1'b0;
    cmd_o.is_close = 1'b0;
    cmd_o.data = rx_byte_i;
    if (take) begin
      if (esc_q) begin
        esc_d = 1'b0;
        if (rx_byte_i == SlEscEsc) begin
          push_o = 1'b1;
          cmd_o.data = SlEsc;
        end else if (rx_byte_i == SlEscEnd) begin
          push_o = 1'b1;
          cmd_o.data = SlEnd;
        end
        // any other byte after esc is dropped
      end else if (rx_byte_i == SlEsc) begin
        esc_d = 1'b1;
      end else if (rx_byte_i == SlEnd) begin
        push_o = 1'b1;
        cmd_o.is_close = 1'b1;
      end else begin
        push_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q <= 1'b0;
    end else begin
      esc_q <= esc_d;
    end
  end

endmodule

[src/slip_queue.sv]
module slip_queue
  import slip_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  slip_cmd_t push_cmd_i,
  input  logic pop_i,
  output logic valid_o,
  output logic full_o,
  output slip_cmd_t head_o
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  slip_cmd_t mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    if (p == PtrW'(QueueDepth - 1)) begin
      return '0;
    end
    return p + PtrW'(1);
  endfunction

  assign valid_o = cnt_q != '0;
  assign full_o = cnt_q == CntW'(QueueDepth);
  assign head_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

[src/slip_back.sv]
module slip_back
  import slip_pkg::*;
#(
  parameter int MAX_FRAME = MaxFrameDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_valid_i,
  input  slip_cmd_t q_cmd_i,
  output logic pop_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic is_frame_end_o,
  output logic [7:0] data_byte_o,
  output logic [10:0] byte_index_o,
  output logic [1:0] frame_verdict_o,
  output logic [11:0] frame_length_o
);

  localparam int CntW = $clog2(MAX_FRAME + 1);

  logic [CntW-1:0] count_q, count_d;
  logic ovf_q, ovf_d;
  logic [3:0] ver_q, ver_d;
  logic [15:0] plen_q, plen_d;
  logic [7:0] nh_q, nh_d;
  logic [7:0] icmp_q, icmp_d;

  logic out_valid_q, out_valid_d;
  logic end_q, end_d;
  logic [7:0] data_q, data_d;
  logic [10:0] idx_q, idx_d;
  verdict_e verdict_q, verdict_d;
  logic [11:0] len_q, len_d;

  logic advance, emit, len_ok;
  verdict_e verdict;

  assign advance = !out_valid_q || !out_stall_i;
  assign pop_o = q_valid_i && advance;
  assign len_ok = ({1'b0, plen_q} + 17'(Ipv6HdrLen)) == 17'(count_q);

  always_comb begin
    if (ovf_q) begin
      verdict = VERDICT_OVERFLOW;
    end else if (ver_q == Ipv6Version && len_ok) begin
      if (count_q > CntW'(Ipv6HdrLen) && nh_q == Icmpv6Nh && icmp_q == RsType) begin
        verdict = VERDICT_RS;
      end else begin
        verdict = VERDICT_FORWARD;
      end
    end else begin
      verdict = VERDICT_DROP;
    end
  end

  always_comb begin
    count_d = count_q;
    ovf_d = ovf_q;
    ver_d = ver_q;
    plen_d = plen_q;
    nh_d = nh_q;
    icmp_d = icmp_q;
    emit = 1'b0;
    end_d = end_q;
    data_d = data_q;
    idx_d = idx_q;
    verdict_d = verdict_q;
    len_d = len_q;
    if (pop_o) begin
      if (q_cmd_i.is_close) begin
        if (count_q != '0 || ovf_q) begin
          emit = 1'b1;
          end_d = 1'b1;
          data_d = '0;
          idx_d = '0;
          verdict_d = verdict;
          len_d = 12'(count_q);
          count_d = '0;
          ovf_d = 1'b0;
          ver_d = '0;
          plen_d = '0;
          nh_d = '0;
          icmp_d = '0;
        end
      end else if (count_q >= CntW'(MAX_FRAME)) begin
        // past the limit: flag only, nothing stored
        ovf_d = 1'b1;
      end else begin
        emit = 1'b1;
        end_d = 1'b0;
        data_d = q_cmd_i.data;
        idx_d = 11'(count_q);
        verdict_d = VERDICT_FORWARD;
        len_d = '0;
        count_d = count_q + CntW'(1);
        if (count_q == '0) ver_d = q_cmd_i.data[7:4];
        if (count_q == CntW'(PlOffHi)) plen_d[15:8] = q_cmd_i.data;
        if (count_q == CntW'(PlOffLo)) plen_d[7:0] = q_cmd_i.data;
        if (count_q == CntW'(NhOff)) nh_d = q_cmd_i.data;
        if (count_q == CntW'(Ipv6HdrLen)) icmp_d = q_cmd_i.data;
      end
    end
    out_valid_d = advance ? emit : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q <= 1'b0;
      ver_q <= '0;
      plen_q <= '0;
      nh_q <= '0;
      icmp_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q <= ovf_d;
      ver_q <= ver_d;
      plen_q <= plen_d;
      nh_q <= nh_d;
      icmp_q <= icmp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    end_q <= end_d;
    data_q <= data_d;
    idx_q <= idx_d;
    verdict_q <= verdict_d;
    len_q <= len_d;
  end

  assign out_valid_o = out_valid_q;
  assign is_frame_end_o = end_q;
  assign data_byte_o = data_q;
  assign byte_index_o = idx_q;
  assign frame_verdict_o = verdict_q;
  assign frame_length_o = len_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_FRAME))
    else $error("byte count beyond frame limit");

  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && q_cmd_i.is_close && emit) |=> (count_q == '0 && !ovf_q))
    else $error("frame state not cleared after verdict");

  a_verdict_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && end_q && verdict_q != VERDICT_OVERFLOW) |-> len_q != '0)
    else $error("verdict for an empty frame");
`endif

endmodule

[src/slip_ipv6_frame_decoder.sv]
// slip receive decoder with ipv6 sanity check
// input channel: one raw line byte per transfer on rx_byte_i (in_valid_i / in_stall_o).
// output channel: one result per transfer (out_valid_o / out_stall_i). a data result
//   (is_frame_end_o = 0) carries the unescaped byte and its index in the frame; a
//   verdict result (is_frame_end_o = 1) closes a non-empty frame with its verdict
//   (0 forward, 1 router solicitation, 2 dropped, 3 overflow) and its length.
// esc bytes, bad escapes, empty frames and bytes past MAX_FRAME give no result.
// each accepted byte passes through the decode queue and then the output register
//   on its way to a result.
// throughput: one byte per cycle while the receiver does not stall, set by the frame
//   state update in the back end, which retires one queued item per cycle.
// when the receiver stalls, the output register holds its result, the two-entry
//   queue fills and then in_stall_o rises; no byte is lost.
// reset clears escape state, the queue, the frame counters and the output valid;
//   the block takes bytes as soon as reset is released.
module slip_ipv6_frame_decoder
  import slip_pkg::*;
#(
  parameter int MAX_FRAME = MaxFrameDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic is_frame_end_o,
  output logic [7:0] data_byte_o,
  output logic [10:0] byte_index_o,
  output logic [1:0] frame_verdict_o,
  output logic [11:0] frame_length_o
);

  logic q_full, q_valid, push, pop;
  slip_cmd_t push_cmd, head_cmd;

  assign in_stall_o = q_full;

  slip_front u_front (
    .clk_i (clk_i),
    .rst_ni (rst_ni),
    .in_valid_i (in_valid_i),
    .rx_byte_i (rx_byte_i),
    .q_full_i (q_full),
    .push_o (push),
    .cmd_o (push_cmd)
  );

  slip_queue u_queue (
    .clk_i (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .push_cmd_i (push_cmd),
    .pop_i (pop),
    .valid_o (q_valid),
    .full_o (q_full),
    .head_o (head_cmd)
  );

  slip_back #(
    .MAX_FRAME (MAX_FRAME)
  ) u_back (
    .clk_i (clk_i),
    .rst_ni (rst_ni),
    .q_valid_i (q_valid),
    .q_cmd_i (head_cmd),
    .pop_o (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .is_frame_end_o (is_frame_end_o),
    .data_byte_o (data_byte_o),
    .byte_index_o (byte_index_o),
    .frame_verdict_o (frame_verdict_o),
    .frame_length_o (frame_length_o)
  );

endmodule
